// ===== design/frustum_point_test_and_clamp_macros.svh =====
// Assertion macros shared by the checker file of the point/frustum block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FRUSTUM_POINT_TEST_AND_CLAMP_MACROS_SVH
`define FRUSTUM_POINT_TEST_AND_CLAMP_MACROS_SVH

// same-cycle implication
`define FPTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fptc_pkg.sv =====
// Package for the point/frustum test block: sizes, payload types, plane
// field extraction and saturation. No dependencies.
`default_nettype none
package fptc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int REG_COUNT   = 6;
	// planes without a register stay zero and never reject, so no cell for them
	localparam int CELL_COUNT  = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

	localparam int IDX_W   = 3;
	localparam int COORD_W = 24;
	localparam int COEF_W  = 13;
	localparam int OFS_W   = 25;
	localparam int PROD_W  = COEF_W + COORD_W;   // a*x, 22 fraction bits
	localparam int DIST_W  = PROD_W + 2;         // sum of four terms
	localparam int PLANE_W = 64;
	localparam int FRAC_SH = 12;                 // Q.22 -> Q.10
	localparam int PPROD_W = DIST_W + COEF_W;    // t*a, 34 fraction bits
	localparam int PDIFF_W = PPROD_W + 1;
	localparam int PROJ_SH = 24;                 // Q.34 -> Q.10
	localparam int WIDE_W  = PDIFF_W - PROJ_SH;  // 29 bits after projection shift
	localparam int DATA_IN_W  = 3 * COORD_W;
	localparam int DATA_OUT_W = 104;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [OFS_W-1:0]   ofs_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DIST_W-1:0]  dist_t;
	typedef logic signed [PPROD_W-1:0] pprod_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic [PLANE_W-1:0]        plane_t;
	typedef logic [IDX_W-1:0]          idx_t;

	// payload handed from cell to cell
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   found;
		idx_t   idx;
		dist_t  t;
		coef_t  a;
		coef_t  b;
		coef_t  c;
	} cell_data_t;

	typedef struct packed {
		logic   in_view;
		idx_t   nearest;
		coord_t plane_dist;
		coord_t cx;
		coord_t cy;
		coord_t cz;
	} result_t;

	function automatic coef_t plane_a(input plane_t p);
		return p[COEF_W-1:0];
	endfunction

	function automatic coef_t plane_b(input plane_t p);
		return p[2*COEF_W-1:COEF_W];
	endfunction

	function automatic coef_t plane_c(input plane_t p);
		return p[3*COEF_W-1:2*COEF_W];
	endfunction

	function automatic ofs_t plane_d(input plane_t p);
		return p[3*COEF_W+OFS_W-1:3*COEF_W];
	endfunction

	// clamp to the coordinate range
	function automatic coord_t sat_coord(input wide_t v);
		logic [WIDE_W-COORD_W:0] hi;
		hi = v[WIDE_W-1:COORD_W-1];
		if (hi == '0 || hi == '1) begin
			return v[COORD_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/fptc_cell.sv =====
// One plane cell: signed distance of the point to its plane, then keeps the
// least-violated plane seen so far. Depends on fptc_pkg.
`default_nettype none
module fptc_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire fptc_pkg::idx_t  cell_idx,
	input  wire fptc_pkg::plane_t plane,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire fptc_pkg::cell_data_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output fptc_pkg::cell_data_t out_data
);
	import fptc_pkg::*;

	logic       v_s1, v_s2;
	logic       rdy_s1, rdy_s2;
	cell_data_t d_s1, d_s2;
	prod_t      ax_s1, by_s1, cz_s1, dd_s1;
	prod_t      ax_c, by_c, cz_c;
	dist_t      t_c;
	logic       take_c;
	cell_data_t nxt_c;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// products first, each on its own multiplier
	assign ax_c = PROD_W'(plane_a(plane)) * PROD_W'(in_data.x);
	assign by_c = PROD_W'(plane_b(plane)) * PROD_W'(in_data.y);
	assign cz_c = PROD_W'(plane_c(plane)) * PROD_W'(in_data.z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			d_s1  <= in_data;
			ax_s1 <= ax_c;
			by_s1 <= by_c;
			cz_s1 <= cz_c;
			dd_s1 <= {plane_d(plane), {FRAC_SH{1'b0}}};
		end
	end

	// sum and compare against the running best
	assign t_c    = DIST_W'(ax_s1) + DIST_W'(by_s1) + DIST_W'(cz_s1) + DIST_W'(dd_s1);
	assign take_c = t_c[DIST_W-1] && (!d_s1.found || (t_c > d_s1.t));

	always_comb begin
		nxt_c = d_s1;
		if (take_c) begin
			nxt_c.found = 1'b1;
			nxt_c.idx   = cell_idx;
			nxt_c.t     = t_c;
			nxt_c.a     = plane_a(plane);
			nxt_c.b     = plane_b(plane);
			nxt_c.c     = plane_c(plane);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			d_s2 <= nxt_c;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule
`default_nettype wire

// ===== design/fptc_proj.sv =====
// Projection stage: p - t*n on the chosen plane, distance rescale and
// saturation, or pass-through when inside. Depends on fptc_pkg.
`default_nettype none
module fptc_proj (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire fptc_pkg::cell_data_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output fptc_pkg::result_t    out_data
);
	import fptc_pkg::*;

	logic       v_s1, v_s2;
	logic       rdy_s1, rdy_s2;
	cell_data_t d_s1;
	pprod_t     pa_s1, pb_s1, pc_s1;
	coord_t     dist_s1;
	result_t    r_s2;
	wide_t      dist_w_c;
	wide_t      px_c, py_c, pz_c;
	logic signed [PDIFF_W-1:0] dx_c, dy_c, dz_c;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// floor shift of t is its upper bits, sign kept
	assign dist_w_c = WIDE_W'($signed(in_data.t[DIST_W-1:FRAC_SH]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			d_s1    <= in_data;
			pa_s1   <= PPROD_W'(in_data.t) * PPROD_W'(in_data.a);
			pb_s1   <= PPROD_W'(in_data.t) * PPROD_W'(in_data.b);
			pc_s1   <= PPROD_W'(in_data.t) * PPROD_W'(in_data.c);
			dist_s1 <= sat_coord(dist_w_c);
		end
	end

	// point aligned to 34 fraction bits minus t*n, then floor back to Q.10
	assign dx_c = PDIFF_W'($signed({d_s1.x, {PROJ_SH{1'b0}}})) - PDIFF_W'(pa_s1);
	assign dy_c = PDIFF_W'($signed({d_s1.y, {PROJ_SH{1'b0}}})) - PDIFF_W'(pb_s1);
	assign dz_c = PDIFF_W'($signed({d_s1.z, {PROJ_SH{1'b0}}})) - PDIFF_W'(pc_s1);
	assign px_c = dx_c[PDIFF_W-1:PROJ_SH];
	assign py_c = dy_c[PDIFF_W-1:PROJ_SH];
	assign pz_c = dz_c[PDIFF_W-1:PROJ_SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			if (d_s1.found) begin
				r_s2.in_view    <= 1'b0;
				r_s2.nearest    <= d_s1.idx;
				r_s2.plane_dist <= dist_s1;
				r_s2.cx         <= sat_coord(px_c);
				r_s2.cy         <= sat_coord(py_c);
				r_s2.cz         <= sat_coord(pz_c);
			end else begin
				r_s2.in_view    <= 1'b1;
				r_s2.nearest    <= '0;
				r_s2.plane_dist <= '0;
				r_s2.cx         <= d_s1.x;
				r_s2.cy         <= d_s1.y;
				r_s2.cz         <= d_s1.z;
			end
		end
	end

	assign out_valid = v_s2;
	assign out_data  = r_s2;

endmodule
`default_nettype wire

// ===== design/frustum_point_test_and_clamp.sv =====
// Point versus frustum test with projection onto the least-violated plane.
// Every plane cell and the projection unit are two-stage pipelines (s1, s2)
// with per-stage flow control, so bubbles collapse; throughput is one point
// per cycle while m_tready accepts results.
// Reset: arst_n clears all valid flags and the plane registers (all planes zero).
// Depends on fptc_pkg, fptc_cell and fptc_proj.
`default_nettype none
module frustum_point_test_and_clamp (
	input  wire                              clk,
	input  wire                              arst_n,
	// input point transaction
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// [23:0] point_x, [47:24] point_y, [71:48] point_z
	input  wire [fptc_pkg::DATA_IN_W-1:0]    s_tdata,
	// result transaction
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// [2:0] nearest_plane, [26:3] plane_distance, [50:27] closest_x,
	// [74:51] closest_y, [98:75] closest_z, [103:99] zero
	output logic [fptc_pkg::DATA_OUT_W-1:0]  m_tdata,
	// [0] inside_res
	output logic                             m_tuser,
	// plane register writes
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire fptc_pkg::idx_t              cfg_index,
	input  wire fptc_pkg::plane_t            cfg_data
);
	import fptc_pkg::*;

	// plane registers, one per cell
	plane_t     plane_q [CELL_COUNT];

	// links of the cell chain; link 0 is the input, the last one feeds projection
	logic       lnk_valid [CELL_COUNT+1];
	logic       lnk_ready [CELL_COUNT+1];
	cell_data_t lnk_data  [CELL_COUNT+1];

	result_t    res;

	// writes take effect at once; out-of-range indices fall through
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < CELL_COUNT; i++) begin
				if (cfg_index == IDX_W'(i)) begin
					plane_q[i] <= cfg_data;
				end
			end
		end
	end

	// unpack the point, no plane chosen yet
	always_comb begin
		lnk_data[0]       = '0;
		lnk_data[0].x     = s_tdata[COORD_W-1:0];
		lnk_data[0].y     = s_tdata[2*COORD_W-1:COORD_W];
		lnk_data[0].z     = s_tdata[3*COORD_W-1:2*COORD_W];
		lnk_data[0].found = 1'b0;
	end
	assign lnk_valid[0] = s_tvalid;
	assign s_tready     = lnk_ready[0];

	// one cell per plane; each keeps the negative distance nearest zero,
	// strict compare so the lower index wins a tie
	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		fptc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (IDX_W'(g)),
			.plane     (plane_q[g]),
			.in_valid  (lnk_valid[g]),
			.in_ready  (lnk_ready[g]),
			.in_data   (lnk_data[g]),
			.out_valid (lnk_valid[g+1]),
			.out_ready (lnk_ready[g+1]),
			.out_data  (lnk_data[g+1])
		);
	end

	// projection and output register
	fptc_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lnk_valid[CELL_COUNT]),
		.in_ready  (lnk_ready[CELL_COUNT]),
		.in_data   (lnk_data[CELL_COUNT]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tuser = res.in_view;
	assign m_tdata = {(DATA_OUT_W - IDX_W - 4*COORD_W)'(0),
		res.cz, res.cy, res.cx, res.plane_dist, res.nearest};

endmodule
`default_nettype wire

// ===== design/fptc_checker.sv =====
// Port-level checker for the point/frustum block, bound to the top level.
// Depends on fptc_pkg and frustum_point_test_and_clamp_macros.svh.
`default_nettype none
`include "frustum_point_test_and_clamp_macros.svh"
module fptc_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [fptc_pkg::DATA_OUT_W-1:0]   m_tdata,
	input wire                              m_tuser
);
	import fptc_pkg::*;

	`FPTC_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`FPTC_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`FPTC_ASSERT_NOW(a_inside_zero, m_tvalid && m_tuser, m_tdata[26:0] == 27'd0, "inside result with plane or distance set")
	`FPTC_ASSERT_NOW(a_outside_neg, m_tvalid && !m_tuser, m_tdata[26] == 1'b1, "outside result with non-negative distance")
	`FPTC_ASSERT_NOW(a_plane_range, m_tvalid && !m_tuser, 32'(m_tdata[2:0]) < CELL_COUNT, "plane index out of range")

endmodule

bind frustum_point_test_and_clamp fptc_checker u_fptc_checker (.*);
`default_nettype wire
